>>> hdl/ftr_pkg.sv
// ----------------------------------------------------------------------------
// ftr_pkg: shared types and constants of the frame time rescaler
// Widths of the datapath, the tick rate and the sideband that rides the
// divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package ftr_pkg;
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned TICK_W   = 20;
    localparam int unsigned RATE_W   = 20;
    localparam int unsigned VAL_W    = 41;
    localparam int unsigned PROD_W   = VAL_W + RATE_W;      // mag * rate
    localparam int unsigned SCALED_W = 80;                  // mag * den * ticks
    localparam int unsigned DVD_W    = SCALED_W + 1;        // 2*A + D
    localparam int unsigned DVS_W    = 2 * RATE_W + 1;      // 2*D
    localparam int unsigned DIV_STEPS = DVD_W;
    localparam int unsigned RES_W    = 64;

    localparam logic [TICK_W-1:0] TICKS = TICK_W'(TICKS_PER_SECOND);

    typedef enum logic {
        REQ_FRAME_TO_TICKS = 1'b0,
        REQ_TICKS_TO_FRAME = 1'b1
    } req_t;

    typedef enum logic {
        REG_RATE_NUM = 1'b0,
        REG_RATE_DEN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic neg;
        logic err;
    } side_t;
endpackage
`default_nettype wire

>>> hdl/ftr_div_pipe.sv
// ----------------------------------------------------------------------------
// ftr_div_pipe: pipelined restoring divider
// One quotient bit per stage; a word may enter in every cycle in which en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module ftr_div_pipe (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [ftr_pkg::DVD_W-1:0]    in_dvd,
    input  wire logic [ftr_pkg::DVS_W-1:0]    in_dvs,
    input  wire ftr_pkg::side_t               in_side,
    output logic                              out_valid,
    output logic [ftr_pkg::DVD_W-1:0]         out_quo,
    output ftr_pkg::side_t                    out_side
);
    localparam int unsigned S = ftr_pkg::DIV_STEPS;
    localparam int unsigned DW = ftr_pkg::DVD_W;
    localparam int unsigned EW = ftr_pkg::DVS_W;

    logic [EW-1:0]  rem_reg  [0:S];
    logic [DW-1:0]  sh_reg   [0:S];
    logic [EW-1:0]  dvs_reg  [0:S];
    ftr_pkg::side_t side_reg [0:S];
    logic           vld_reg  [0:S];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0]  <= '0;
            sh_reg[0]   <= in_dvd;
            dvs_reg[0]  <= in_dvs;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= S; k++) begin : g_step
        logic [EW:0]   trial;
        logic [EW:0]   diff;
        logic          take;
        logic [EW-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[k-1], sh_reg[k-1][DW-1]};
            diff     = trial - {1'b0, dvs_reg[k-1]};
            take     = (trial >= {1'b0, dvs_reg[k-1]});
            rem_next = take ? diff[EW-1:0] : trial[EW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                sh_reg[k]   <= {sh_reg[k-1][DW-2:0], take};
                dvs_reg[k]  <= dvs_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[S];
    assign out_quo   = sh_reg[S];
    assign out_side  = side_reg[S];
endmodule
`default_nettype wire

>>> hdl/frame_time_rescaler_unit.sv
// ----------------------------------------------------------------------------
// frame_time_rescaler_unit: frame index <-> microsecond conversion
// Rational frame rate rate_num/rate_den, rounding half away from zero.
// ----------------------------------------------------------------------------
// A word is accepted in every cycle unless the output is stalled. It passes
// three multiply/setup stages, one divider load stage, 81 one-bit divider
// stages set by the 81-bit dividend and one output stage. The result is the
// magnitude rounded as round(mag*M/D) = floor((2*mag*M + D) / (2*D)), with
// M/D = rate_den*1e6/rate_num for frame to microseconds and
// rate_num/(rate_den*1e6) the other way, then the sign of value_in applied.
// A zero rate register gives 0 with rate_error; a result beyond the signed
// 64-bit range saturates with overflow. Write the rate registers only while
// idle. The whole pipeline holds when the output word is stalled.
`default_nettype none
module frame_time_rescaler_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [40:0] value_in, [47:41] zero
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] result_value
    output logic [1:0]       m_tuser    // [0] rate_error, [1] overflow
);
    localparam int unsigned RW = ftr_pkg::RATE_W;
    localparam int unsigned VW = ftr_pkg::VAL_W;
    localparam int unsigned PW = ftr_pkg::PROD_W;
    localparam int unsigned AW = ftr_pkg::SCALED_W;
    localparam int unsigned DW = ftr_pkg::DVD_W;
    localparam int unsigned EW = ftr_pkg::DVS_W;

    logic [RW-1:0] rate_num_reg, rate_den_reg;
    logic          en;

    // Hold everything while the output word waits.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_num_reg <= RW'(30);
            rate_den_reg <= RW'(1);
        end else if (cfg_we) begin
            case (ftr_pkg::reg_idx_t'(cfg_index))
                ftr_pkg::REG_RATE_NUM: rate_num_reg <= cfg_wdata;
                ftr_pkg::REG_RATE_DEN: rate_den_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: sign and magnitude.
    logic          v1_reg, typ1_reg;
    logic [VW-1:0] mag1_reg;
    ftr_pkg::side_t side1_reg;
    logic [VW-1:0] value_in;
    assign value_in = s_tdata[VW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            typ1_reg      <= s_tuser;
            mag1_reg      <= value_in[VW-1] ? (~value_in + VW'(1)) : value_in;
            side1_reg.neg <= value_in[VW-1];
            side1_reg.err <= (rate_num_reg == '0) || (rate_den_reg == '0);
        end
    end

    // Stage 2: mag times the rate register on the numerator side; divisor.
    logic            v2_reg, typ2_reg;
    logic [PW-1:0]   prod2_reg;
    logic [2*RW-1:0] dvs2_reg;
    ftr_pkg::side_t  side2_reg;
    logic [RW-1:0]   mult1;
    assign mult1 = (typ1_reg == ftr_pkg::REQ_FRAME_TO_TICKS) ? rate_den_reg : rate_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            typ2_reg  <= typ1_reg;
            side2_reg <= side1_reg;
            prod2_reg <= PW'(mag1_reg) * PW'(mult1);
            dvs2_reg  <= (typ1_reg == ftr_pkg::REQ_FRAME_TO_TICKS)
                         ? (2*RW)'(rate_num_reg)
                         : (2*RW)'(rate_den_reg) * (2*RW)'(ftr_pkg::TICKS);
        end
    end

    // Stage 3: apply the tick rate on the frame to microseconds path.
    logic            v3_reg;
    logic [AW-1:0]   a3_reg;
    logic [2*RW-1:0] dvs3_reg;
    ftr_pkg::side_t  side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            side3_reg <= side2_reg;
            dvs3_reg  <= dvs2_reg;
            a3_reg    <= (typ2_reg == ftr_pkg::REQ_FRAME_TO_TICKS)
                         ? AW'(prod2_reg) * AW'(ftr_pkg::TICKS)
                         : AW'(prod2_reg);
        end
    end

    // Rounding bias folded into the dividend: (2A + D) / (2D).
    logic [DW-1:0] dvd;
    logic [EW-1:0] dvs;
    assign dvd = {a3_reg, 1'b0} + DW'(dvs3_reg);
    assign dvs = {dvs3_reg, 1'b0};

    logic           dv_valid;
    logic [DW-1:0]  quo;
    ftr_pkg::side_t dv_side;

    ftr_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_dvd    (dvd),
        .in_dvs    (dvs),
        .in_side   (side3_reg),
        .out_valid (dv_valid),
        .out_quo   (quo),
        .out_side  (dv_side)
    );

    // Output stage: saturate, apply sign, drop the value on a rate error.
    logic        ovf;
    logic [63:0] mag_res;
    logic [63:0] m_tdata_next;
    logic [1:0]  m_tuser_next;

    always_comb begin
        if (dv_side.neg) begin
            ovf = (|quo[DW-1:64]) || (quo[63] && (|quo[62:0]));
        end else begin
            ovf = |quo[DW-1:63];
        end
        if (ovf) begin
            mag_res = dv_side.neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            mag_res = quo[63:0];
        end
        if (dv_side.err) begin
            m_tdata_next = '0;
            m_tuser_next = 2'b01;
        end else begin
            m_tdata_next = dv_side.neg ? (~mag_res + 64'd1) : mag_res;
            m_tuser_next = {ovf, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= dv_valid;
        end
        if (en) begin
            m_tdata <= m_tdata_next;
            m_tuser <= m_tuser_next;
        end
    end
endmodule
`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for frame_time_rescaler_unit
// Streams conversion requests in both directions under a series of frame
// rates, predicts every result with exact wide arithmetic and compares each
// output word field by field. Both sides idle at random, and one long output
// stall backs the pipeline up into the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;

    localparam int WATCHDOG_LIMIT = 4000;    // cycles with no word moving
    localparam int DRAIN_CYCLES   = 120;     // extra wait after the last result is back
    localparam int LONG_HOLD      = 400;     // output hold-off, fills the pipe

    typedef struct {
        ftr_pkg::req_t kind;
        logic [40:0]   value;
    } conv_req_t;

    typedef struct {
        logic [63:0] value;
        logic        rate_err;
        logic        ovf;
    } conv_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [40:0] value_in, [47:41] zero
    logic        s_tuser = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [63:0] result_value
    logic [1:0]  m_tuser;        // [0] rate_error, [1] overflow

    conv_req_t pending_reqs[$];
    conv_res_t expected_results[$];

    // shadow of the rate registers, used by the predictor
    logic [19:0] shadow_num = 20'd30;
    logic [19:0] shadow_den = 20'd1;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    bit hold_req   = 1'b0;
    int tx_gap     = 0;
    int rx_stall   = 0;
    int hold_left  = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    frame_time_rescaler_unit dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: split into truncated quotient and remainder, scale the
    // quotient exactly, round the scaled remainder half up, then saturate
    // and apply the sign of the input.
    // ------------------------------------------------------------------------
    function automatic conv_res_t rescale_time(ftr_pkg::req_t kind, logic [40:0] v);
        conv_res_t   res;
        logic        neg;
        logic [40:0] mag;
        logic [127:0] dvs, q, r, rr, scale, total, limit;
        neg = v[40];
        mag = neg ? -v : v;
        res.rate_err = 1'b0;
        res.ovf = 1'b0;
        if (shadow_num == 0 || shadow_den == 0) begin
            res.value = '0;
            res.rate_err = 1'b1;
            return res;
        end
        if (kind == ftr_pkg::REQ_FRAME_TO_TICKS) begin
            dvs = 128'(shadow_num);
            q = (128'(mag) * shadow_den) / dvs;
            r = (128'(mag) * shadow_den) % dvs;
            scale = 128'(ftr_pkg::TICKS_PER_SECOND);
        end else begin
            dvs = 128'(shadow_den) * ftr_pkg::TICKS_PER_SECOND;
            q = 128'(mag) / dvs;
            r = 128'(mag) % dvs;
            scale = 128'(shadow_num);
        end
        // round(r*scale/dvs) with halves going up
        rr = (2 * r * scale + dvs) / (2 * dvs);
        total = q * scale + rr;
        limit = neg ? (128'(1) << 63) : ((128'(1) << 63) - 1);
        if (total > limit) begin
            total = limit;
            res.ovf = 1'b1;
        end
        res.value = neg ? -total[63:0] : total[63:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold the word while stalled, predict on acceptance, then idle
    // for the drawn gap before offering the next pending request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        conv_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid)
                expected_results.push_back(
                    rescale_time(ftr_pkg::req_t'(s_tuser), s_tdata[40:0]));
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'b0, nxt.value};
                s_tuser <= nxt.kind;
                tx_gap <= tx_idle_on ? $urandom_range(0, 19) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each output word against the oldest prediction, and
    // drive tready from a per-word stall draw or a long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        conv_res_t want;
        int ns;
        int hl;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
            hold_left <= 0;
        end else begin
            ns = rx_stall;
            hl = hold_left;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: value=%h user=%b", m_tdata, m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value || m_tuser[0] !== want.rate_err ||
                        m_tuser[1] !== want.ovf) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp value=%h err=%b ovf=%b, ",
                                      "got value=%h err=%b ovf=%b"},
                                     want.value, want.rate_err, want.ovf,
                                     m_tdata, m_tuser[0], m_tuser[1]);
                    end
                end
                ns = rx_idle_on ? $urandom_range(0, 19) : 0;
            end else if (ns > 0) begin
                ns = ns - 1;
            end
            if (hold_req && hl == 0)
                hl = LONG_HOLD;
            else if (hl > 0)
                hl = hl - 1;
            rx_stall <= ns;
            hold_left <= hl;
            m_tready <= (ns == 0) && (hl == 0);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_rate(ftr_pkg::reg_idx_t idx, logic [19:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == ftr_pkg::REG_RATE_NUM)
            shadow_num = val;
        else
            shadow_den = val;
    endtask

    task automatic queue_req(ftr_pkg::req_t kind, logic [40:0] v);
        conv_req_t it;
        it.kind = kind;
        it.value = v;
        pending_reqs.push_back(it);
    endtask

    // wait until every request has gone in and every result has come back
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(logic [19:0] num, logic [19:0] den, int n_rand);
        logic [40:0] v;
        write_rate(ftr_pkg::REG_RATE_NUM, num);
        write_rate(ftr_pkg::REG_RATE_DEN, den);
        // extremes and rounding edges in both directions
        for (int k = 0; k < 2; k++) begin
            queue_req(ftr_pkg::req_t'(k), 41'd0);
            queue_req(ftr_pkg::req_t'(k), 41'd1);
            queue_req(ftr_pkg::req_t'(k), -41'sd1);
            queue_req(ftr_pkg::req_t'(k), {1'b0, {40{1'b1}}});
            queue_req(ftr_pkg::req_t'(k), {1'b1, 40'b0});
            queue_req(ftr_pkg::req_t'(k), 41'd500000);
            queue_req(ftr_pkg::req_t'(k), -41'sd500000);
        end
        for (int i = 0; i < n_rand; i++) begin
            case ($urandom_range(0, 3))
                0: v = 41'({$urandom, $urandom});
                1: v = 41'($signed($urandom_range(0, 4000)) - 2000);
                2: v = 41'($signed($urandom_range(0, 4000000)) - 2000000);
                default: v = {{20{$urandom_range(0, 1) == 1}}, 21'($urandom)};
            endcase
            queue_req(ftr_pkg::req_t'($urandom_range(0, 1)), v);
        end
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        run_phase(20'd30, 20'd1, 110);
        run_phase(20'd0, 20'd1, 20);
        run_phase(20'd1, 20'd0, 20);
        run_phase(20'd1, 20'd1, 110);
        run_phase(20'd64, 20'd1, 100);
        run_phase(20'hFFFFF, 20'hFFFFF, 110);
        run_phase(20'd1, 20'hFFFFF, 110);
        run_phase(20'hFFFFF, 20'd1, 110);
        run_phase(20'd24000, 20'd1001, 110);
        run_phase(20'd25, 20'd1, 110);

        // back the pipeline up: stall the output while the input keeps going
        write_rate(ftr_pkg::REG_RATE_NUM, 20'($urandom_range(1, 20'hFFFFF)));
        write_rate(ftr_pkg::REG_RATE_DEN, 20'($urandom_range(1, 20'hFFFFF)));
        tx_idle_on = 1'b0;
        for (int i = 0; i < 200; i++)
            queue_req(ftr_pkg::req_t'($urandom_range(0, 1)), 41'({$urandom, $urandom}));
        @(negedge aclk);
        hold_req = 1'b1;
        @(negedge aclk);
        hold_req = 1'b0;
        drain();

        for (int p = 0; p < 2; p++)
            run_phase(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 5000)), 10);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/ftr_pkg.sv
hdl/ftr_div_pipe.sv
hdl/frame_time_rescaler_unit.sv
dv/tb.sv
